// ===== design/bmma_pkg.sv =====
package bmma_pkg;

	localparam int DATA_W = 10;
	localparam int GAUGE_W = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int WINDOW_DEFAULT = 8;
	localparam int GAUGE_SEGMENTS_DEFAULT = 20;

	localparam logic [DATA_W-1:0] FULL_RESET = 10'd1023;
	localparam logic [DATA_W-1:0] EMPTY_RESET = 10'd600;
	localparam logic [DATA_W-1:0] LOW_RESET = 10'd700;
	localparam logic [DATA_W-1:0] DEADBAND_RESET = 10'd32;
	localparam logic [DATA_W-1:0] STICK_MID = 10'd512;

	typedef enum logic [1:0] {
		REG_FULL_LEVEL     = 2'd0,
		REG_EMPTY_LEVEL    = 2'd1,
		REG_LOW_LEVEL      = 2'd2,
		REG_STICK_DEADBAND = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0]  battery_average;
		logic [DATA_W-1:0]  enable_average;
		logic               low_battery;
		logic               charge_needed;
		logic               switch_on;
		logic               stick_centered;
		logic [GAUGE_W-1:0] gauge_segment;
	} res_t;

endpackage

// ===== design/bmma_fifo.sv =====
module bmma_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PTR_W = $clog2(bmma_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(bmma_pkg::QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [bmma_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(bmma_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(bmma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(bmma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== design/bmma_front.sv =====
module bmma_front #(
	parameter int WINDOW = bmma_pkg::WINDOW_DEFAULT,
	parameter int SUM_W = $clog2(WINDOW * 1023 + 1),
	parameter int Q_W = 2 * SUM_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [bmma_pkg::DATA_W-1:0] stick_x,
	input  logic [bmma_pkg::DATA_W-1:0] stick_y,
	input  logic [bmma_pkg::DATA_W-1:0] battery_sample,
	input  logic [bmma_pkg::DATA_W-1:0] enable_sample,
	input  logic [bmma_pkg::DATA_W-1:0] stick_deadband,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [Q_W-1:0]              q_data
);

	localparam int DW = bmma_pkg::DATA_W;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * 1023);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_UPD  = 2'b10
	} front_state_t;

	front_state_t      state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WINDOW-1:0] valid_q;
	logic [SUM_W-1:0]  bsum_q;
	logic [SUM_W-1:0]  esum_q;
	logic [2*DW-1:0]   ring [WINDOW];
	logic [2*DW-1:0]   rd_s1;
	logic [DW-1:0]     sx_s1;
	logic [DW-1:0]     sy_s1;
	logic [DW-1:0]     bs_s1;
	logic [DW-1:0]     es_s1;

	logic              accept;
	logic [DW-1:0]     old_b;
	logic [DW-1:0]     old_e;
	logic [SUM_W-1:0]  bsum_nxt;
	logic [SUM_W-1:0]  esum_nxt;
	logic [DW-1:0]     dist_x;
	logic [DW-1:0]     dist_y;
	logic              centered;

	assign full = (state_q != F_IDLE);
	assign accept = push && !full;
	assign q_push = (state_q == F_UPD) && !q_full;

	always_comb begin
		old_b = valid_q[slot_q] ? rd_s1[2*DW-1:DW] : bmma_pkg::FULL_RESET;
		old_e = valid_q[slot_q] ? rd_s1[DW-1:0] : bmma_pkg::FULL_RESET;
		bsum_nxt = bsum_q - SUM_W'(old_b) + SUM_W'(bs_s1);
		esum_nxt = esum_q - SUM_W'(old_e) + SUM_W'(es_s1);
		dist_x = (sx_s1 >= bmma_pkg::STICK_MID) ? sx_s1 - bmma_pkg::STICK_MID
			: bmma_pkg::STICK_MID - sx_s1;
		dist_y = (sy_s1 >= bmma_pkg::STICK_MID) ? sy_s1 - bmma_pkg::STICK_MID
			: bmma_pkg::STICK_MID - sy_s1;
		centered = (dist_x < stick_deadband) && (dist_y < stick_deadband);
		q_data = {bsum_nxt, esum_nxt, centered};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			slot_q <= '0;
			valid_q <= '0;
			bsum_q <= SUM_RESET;
			esum_q <= SUM_RESET;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_UPD;
					end
				end
				F_UPD: begin
					if (q_push) begin
						state_q <= F_IDLE;
						bsum_q <= bsum_nxt;
						esum_q <= esum_nxt;
						valid_q[slot_q] <= 1'b1;
						slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sx_s1 <= stick_x;
			sy_s1 <= stick_y;
			bs_s1 <= battery_sample;
			es_s1 <= enable_sample;
		end
	end

	// ring of past samples, read ahead at accept, written on hand-off
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= ring[slot_q];
		end
		if (q_push) begin
			ring[slot_q] <= {bs_s1, es_s1};
		end
	end

	a_push_only_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (state_q == F_UPD) && !q_full)
		else $error("front hands off an item outside the update state");

	a_slot_marked: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> valid_q[$past(slot_q)] && (slot_q != $past(slot_q)))
		else $error("ring slot not marked or not advanced");

	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == F_UPD) && full)
		else $error("accepted item not taken to update");

endmodule

// ===== design/bmma_back.sv =====
module bmma_back #(
	parameter int WINDOW = bmma_pkg::WINDOW_DEFAULT,
	parameter int GAUGE_SEGMENTS = bmma_pkg::GAUGE_SEGMENTS_DEFAULT,
	parameter int SUM_W = $clog2(WINDOW * 1023 + 1),
	parameter int Q_W = 2 * SUM_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic [Q_W-1:0]              q_data,
	input  logic [bmma_pkg::DATA_W-1:0] full_level,
	input  logic [bmma_pkg::DATA_W-1:0] empty_level,
	input  logic [bmma_pkg::DATA_W-1:0] low_level,
	input  logic                        out_full,
	output logic                        out_push,
	output bmma_pkg::res_t              out_data
);

	localparam int DW = bmma_pkg::DATA_W;
	localparam int NUM_W = $clog2(WINDOW * 1023 + WINDOW / 2 + 1);
	localparam int SH = NUM_W + $clog2(WINDOW);
	localparam int RECIP_W = NUM_W + 2;
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SH + WINDOW - 1) / WINDOW);
	localparam logic [NUM_W-1:0] HALF = NUM_W'(WINDOW / 2);
	localparam int GN_W = $clog2(GAUGE_SEGMENTS * 1023 + 1);
	localparam int CNT_W = $clog2(GN_W);
	localparam int QW = $clog2(GAUGE_SEGMENTS);
	localparam int SEG_W = (QW > bmma_pkg::GAUGE_W) ? QW : bmma_pkg::GAUGE_W;
	localparam logic [GN_W-1:0] GAUGE_C = GN_W'(GAUGE_SEGMENTS);
	localparam logic [GN_W-1:0] GAUGE_TOP = GN_W'(GAUGE_SEGMENTS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_AVG  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} back_state_t;

	back_state_t       state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] prod_b_s1;
	logic [PROD_W-1:0] prod_e_s1;
	logic              stc_s1;
	logic [DW-1:0]     bavg_q;
	logic [DW-1:0]     eavg_q;
	logic              low_q;
	logic              chg_q;
	logic              sw_q;
	logic              gz_q;
	logic [GN_W-1:0]   num_q;
	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q;

	logic [SUM_W-1:0]  bsum;
	logic [SUM_W-1:0]  esum;
	logic [NUM_W-1:0]  numer_b;
	logic [NUM_W-1:0]  numer_e;
	logic [DW-1:0]     bavg;
	logic [DW-1:0]     eavg;
	logic [DW-1:0]     adiff;
	logic [DW:0]       shifted;
	logic              ge;
	logic [QW-1:0]     seg;
	logic [SEG_W-1:0]  seg_ext;

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign out_push = (state_q == S_OUT) && !out_full;

	always_comb begin
		bsum = q_data[Q_W-1 -: SUM_W];
		esum = q_data[SUM_W:1];
		numer_b = NUM_W'(bsum) + HALF;
		numer_e = NUM_W'(esum) + HALF;
		bavg = prod_b_s1[SH +: DW];
		eavg = prod_e_s1[SH +: DW];
		adiff = (eavg >= bavg) ? eavg - bavg : bavg - eavg;
		shifted = {rem_q, num_q[GN_W-1]};
		ge = (shifted >= {1'b0, den_q});
		seg = (num_q > GAUGE_TOP) ? QW'(GAUGE_SEGMENTS - 1) : num_q[QW-1:0];
		seg_ext = gz_q ? '0 : SEG_W'(seg);
		out_data.battery_average = bavg_q;
		out_data.enable_average = eavg_q;
		out_data.low_battery = low_q;
		out_data.charge_needed = chg_q;
		out_data.switch_on = sw_q;
		out_data.stick_centered = stc_s1;
		out_data.gauge_segment = seg_ext[bmma_pkg::GAUGE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					state_q <= S_DIV;
					cnt_q <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(GN_W - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// rounded mean by reciprocal multiply, then restoring divide for the gauge
	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_b_s1 <= PROD_W'(numer_b) * PROD_W'(RECIP);
			prod_e_s1 <= PROD_W'(numer_e) * PROD_W'(RECIP);
			stc_s1 <= q_data[0];
		end
		if (state_q == S_AVG) begin
			bavg_q <= bavg;
			eavg_q <= eavg;
			low_q <= (bavg < low_level);
			chg_q <= (bavg < empty_level);
			sw_q <= (adiff < DW'(WINDOW));
			gz_q <= (full_level <= empty_level) || (bavg < empty_level);
			num_q <= GAUGE_C * GN_W'(bavg - empty_level);
			den_q <= full_level - empty_level;
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q <= ge ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
			num_q <= {num_q[GN_W-2:0], ge};
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_AVG))
		else $error("popped item not taken to averaging");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && $past(state_q == S_DIV) |-> (cnt_q == CNT_W'(GN_W)))
		else $error("gauge divide ended early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_full |=> (state_q == S_OUT) && $stable(out_data))
		else $error("result lost while output queue full");

endmodule

// ===== design/battery_monitor_moving_average.sv =====
// channel  | handshake            | payload
// in       | push / full          | stick_x, stick_y, battery_sample, enable_sample
// out      | pop / empty          | battery_average .. gauge_segment
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// front takes one item at a time: accept with ring read, then sum update and hand-off
// back steps through idle, averaging, a bit-serial restoring divide for the gauge
// and output, and takes no new item until its result is pushed
// a 2-entry queue sits between front and back and on the result side
// reset presets the rings to full level through per-slot valid bits, no sweep
module battery_monitor_moving_average #(
	parameter int WINDOW = bmma_pkg::WINDOW_DEFAULT,
	parameter int GAUGE_SEGMENTS = bmma_pkg::GAUGE_SEGMENTS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [bmma_pkg::DATA_W-1:0]  stick_x,
	input  logic [bmma_pkg::DATA_W-1:0]  stick_y,
	input  logic [bmma_pkg::DATA_W-1:0]  battery_sample,
	input  logic [bmma_pkg::DATA_W-1:0]  enable_sample,
	output logic                         empty,
	input  logic                         pop,
	output logic [bmma_pkg::DATA_W-1:0]  battery_average,
	output logic [bmma_pkg::DATA_W-1:0]  enable_average,
	output logic                         low_battery,
	output logic                         charge_needed,
	output logic                         switch_on,
	output logic                         stick_centered,
	output logic [bmma_pkg::GAUGE_W-1:0] gauge_segment,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [bmma_pkg::DATA_W-1:0]  cfg_data
);

	localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
	localparam int Q_W = 2 * SUM_W + 1;
	localparam int RES_W = $bits(bmma_pkg::res_t);

	logic [bmma_pkg::DATA_W-1:0] full_level_q;
	logic [bmma_pkg::DATA_W-1:0] empty_level_q;
	logic [bmma_pkg::DATA_W-1:0] low_level_q;
	logic [bmma_pkg::DATA_W-1:0] deadband_q;

	logic             mq_push;
	logic             mq_full;
	logic [Q_W-1:0]   mq_din;
	logic             mq_pop;
	logic             mq_empty;
	logic [Q_W-1:0]   mq_dout;
	logic             rq_push;
	logic             rq_full;
	bmma_pkg::res_t   rq_din;
	logic [RES_W-1:0] rq_dout;
	bmma_pkg::res_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_level_q <= bmma_pkg::FULL_RESET;
			empty_level_q <= bmma_pkg::EMPTY_RESET;
			low_level_q <= bmma_pkg::LOW_RESET;
			deadband_q <= bmma_pkg::DEADBAND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bmma_pkg::cfg_reg_t'(cfg_index))
				bmma_pkg::REG_FULL_LEVEL:     full_level_q <= cfg_data;
				bmma_pkg::REG_EMPTY_LEVEL:    empty_level_q <= cfg_data;
				bmma_pkg::REG_LOW_LEVEL:      low_level_q <= cfg_data;
				bmma_pkg::REG_STICK_DEADBAND: deadband_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bmma_front #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W),
		.Q_W    (Q_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.stick_x        (stick_x),
		.stick_y        (stick_y),
		.battery_sample (battery_sample),
		.enable_sample  (enable_sample),
		.stick_deadband (deadband_q),
		.q_full         (mq_full),
		.q_push         (mq_push),
		.q_data         (mq_din)
	);

	bmma_fifo #(
		.W (Q_W)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.din    (mq_din),
		.full   (mq_full),
		.pop    (mq_pop),
		.dout   (mq_dout),
		.empty  (mq_empty)
	);

	bmma_back #(
		.WINDOW         (WINDOW),
		.GAUGE_SEGMENTS (GAUGE_SEGMENTS),
		.SUM_W          (SUM_W),
		.Q_W            (Q_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (mq_empty),
		.q_pop       (mq_pop),
		.q_data      (mq_dout),
		.full_level  (full_level_q),
		.empty_level (empty_level_q),
		.low_level   (low_level_q),
		.out_full    (rq_full),
		.out_push    (rq_push),
		.out_data    (rq_din)
	);

	bmma_fifo #(
		.W (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign res = bmma_pkg::res_t'(rq_dout);
	assign battery_average = res.battery_average;
	assign enable_average = res.enable_average;
	assign low_battery = res.low_battery;
	assign charge_needed = res.charge_needed;
	assign switch_on = res.switch_on;
	assign stick_centered = res.stick_centered;
	assign gauge_segment = res.gauge_segment;

endmodule

// ===== sim/battery_monitor_moving_average_test.sv =====
class window_average_tracker;
	localparam int WIN = bmma_pkg::WINDOW_DEFAULT;
	localparam int SEGMENTS = bmma_pkg::GAUGE_SEGMENTS_DEFAULT;
	localparam int MID = int'(bmma_pkg::STICK_MID);

	int full_level;
	int empty_level;
	int low_level;
	int deadband;
	int battery_ring[WIN];
	int enable_ring[WIN];
	int slot;
	int battery_total;
	int enable_total;
	bmma_pkg::res_t awaited_readings[$];
	int mismatch_count;

	function new();
		full_level = int'(bmma_pkg::FULL_RESET);
		empty_level = int'(bmma_pkg::EMPTY_RESET);
		low_level = int'(bmma_pkg::LOW_RESET);
		deadband = int'(bmma_pkg::DEADBAND_RESET);
		foreach (battery_ring[i]) begin
			battery_ring[i] = int'(bmma_pkg::FULL_RESET);
			enable_ring[i] = int'(bmma_pkg::FULL_RESET);
		end
		slot = 0;
		battery_total = WIN * int'(bmma_pkg::FULL_RESET);
		enable_total = WIN * int'(bmma_pkg::FULL_RESET);
		mismatch_count = 0;
	endfunction

	function void write_level(bmma_pkg::cfg_reg_t idx, logic [9:0] value);
		case (idx)
			bmma_pkg::REG_FULL_LEVEL: full_level = int'(value);
			bmma_pkg::REG_EMPTY_LEVEL: empty_level = int'(value);
			bmma_pkg::REG_LOW_LEVEL: low_level = int'(value);
			bmma_pkg::REG_STICK_DEADBAND: deadband = int'(value);
			default: ;
		endcase
	endfunction

	function int off_mid(logic [9:0] v);
		int d;
		d = int'(v) - MID;
		return (d < 0) ? -d : d;
	endfunction

	function void note_samples(logic [9:0] sx, logic [9:0] sy, logic [9:0] bs,
			logic [9:0] es);
		bmma_pkg::res_t r;
		int bavg;
		int eavg;
		int gap;
		int seg;
		battery_total = battery_total - battery_ring[slot] + int'(bs);
		enable_total = enable_total - enable_ring[slot] + int'(es);
		battery_ring[slot] = int'(bs);
		enable_ring[slot] = int'(es);
		slot = (slot + 1) % WIN;
		bavg = (battery_total + WIN / 2) / WIN;
		eavg = (enable_total + WIN / 2) / WIN;
		gap = (eavg >= bavg) ? eavg - bavg : bavg - eavg;
		seg = 0;
		if (full_level > empty_level && bavg >= empty_level) begin
			seg = SEGMENTS * (bavg - empty_level) / (full_level - empty_level);
			if (seg > SEGMENTS - 1)
				seg = SEGMENTS - 1;
		end
		r.battery_average = bavg[9:0];
		r.enable_average = eavg[9:0];
		r.low_battery = (bavg < low_level);
		r.charge_needed = (bavg < empty_level);
		r.switch_on = (gap < WIN);
		r.stick_centered = (off_mid(sx) < deadband) && (off_mid(sy) < deadband);
		r.gauge_segment = seg[4:0];
		awaited_readings.push_back(r);
	endfunction

	function void flag_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", what);
	endfunction

	function void compare_field(string name, logic [9:0] want_v, logic [9:0] got_v);
		if (got_v !== want_v)
			flag_mismatch($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
	endfunction

	function void check_reading(bmma_pkg::res_t got);
		bmma_pkg::res_t want;
		if (awaited_readings.size() == 0) begin
			flag_mismatch("item on the result side with nothing awaited");
			return;
		end
		want = awaited_readings.pop_front();
		compare_field("battery_average", want.battery_average, got.battery_average);
		compare_field("enable_average", want.enable_average, got.enable_average);
		compare_field("low_battery", 10'(want.low_battery), 10'(got.low_battery));
		compare_field("charge_needed", 10'(want.charge_needed), 10'(got.charge_needed));
		compare_field("switch_on", 10'(want.switch_on), 10'(got.switch_on));
		compare_field("stick_centered", 10'(want.stick_centered),
			10'(got.stick_centered));
		compare_field("gauge_segment", 10'(want.gauge_segment), 10'(got.gauge_segment));
	endfunction
endclass

module battery_monitor_moving_average_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 113;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [9:0] stick_x = '0;
	logic [9:0] stick_y = '0;
	logic [9:0] battery_sample = '0;
	logic [9:0] enable_sample = '0;
	logic empty;
	logic pop = 1'b0;
	logic [9:0] battery_average;
	logic [9:0] enable_average;
	logic low_battery;
	logic charge_needed;
	logic switch_on;
	logic stick_centered;
	logic [4:0] gauge_segment;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	window_average_tracker board = new();
	int stalled = 0;
	int sender_calm = 0;
	int level_full;
	int level_empty;
	int level_low;
	int level_band;
	int battery_target = 1023;

	battery_monitor_moving_average dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin : observe
		bmma_pkg::res_t got;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
			if (cfg_valid && cfg_ready)
				board.write_level(bmma_pkg::cfg_reg_t'(cfg_index), cfg_data);
			if (push && !full)
				board.note_samples(stick_x, stick_y, battery_sample, enable_sample);
			if (pop && !empty) begin
				got = {battery_average, enable_average, low_battery, charge_needed,
					switch_on, stick_centered, gauge_segment};
				board.check_reading(got);
			end
			if (stalled >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [9:0] clamp10(int v);
		if (v < 0)
			return 10'd0;
		if (v > 1023)
			return 10'd1023;
		return v[9:0];
	endfunction

	task automatic send_samples(input logic [9:0] sx, input logic [9:0] sy,
			input logic [9:0] bs, input logic [9:0] es);
		int gap;
		bit taken;
		if (sender_calm > 0) begin
			sender_calm--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 40) == 0)
				sender_calm = 25;
		end
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		stick_x = sx;
		stick_y = sy;
		battery_sample = bs;
		enable_sample = es;
		push = 1'b1;
		do begin
			@(posedge clk);
			taken = !full;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		push = 1'b0;
		while (board.awaited_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_level(input bmma_pkg::cfg_reg_t idx, input logic [9:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_levels(input int f, input int e, input int l, input int d);
		level_full = f;
		level_empty = e;
		level_low = l;
		level_band = d;
		program_level(bmma_pkg::REG_FULL_LEVEL, f[9:0]);
		program_level(bmma_pkg::REG_EMPTY_LEVEL, e[9:0]);
		program_level(bmma_pkg::REG_LOW_LEVEL, l[9:0]);
		program_level(bmma_pkg::REG_STICK_DEADBAND, d[9:0]);
		cfg_valid = 1'b0;
	endtask

	task automatic draw_samples(output logic [9:0] sx, output logic [9:0] sy,
			output logic [9:0] bs, output logic [9:0] es);
		int span;
		int lo;
		int hi;
		span = level_band + 2;
		case ($urandom_range(0, 3))
			0: begin
				sx = 10'($urandom_range(0, 1023));
				sy = 10'($urandom_range(0, 1023));
			end
			1, 2: begin
				sx = clamp10(512 + int'($urandom_range(0, 2 * span)) - span);
				sy = clamp10(512 + int'($urandom_range(0, 2 * span)) - span);
			end
			default: begin
				sx = clamp10(512 + int'($urandom_range(0, 2 * span)) - span);
				sy = 10'($urandom_range(0, 1023));
			end
		endcase
		if ($urandom_range(0, 15) == 0) begin
			lo = (level_empty < level_full) ? level_empty : level_full;
			hi = (level_empty < level_full) ? level_full : level_empty;
			case ($urandom_range(0, 4))
				0: battery_target = $urandom_range(0, 1023);
				1: battery_target = level_empty;
				2: battery_target = level_low;
				3: battery_target = level_full;
				default: battery_target = $urandom_range(lo, hi);
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			bs = 10'($urandom_range(0, 1023));
		else
			bs = clamp10(battery_target + int'($urandom_range(0, 8)) - 4);
		case ($urandom_range(0, 3))
			0, 1: es = clamp10(int'(bs) + int'($urandom_range(0, 20)) - 10);
			2: es = 10'($urandom_range(0, 1023));
			default: es = ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
		endcase
	endtask

	initial begin : result_drain
		int gap;
		int taken_count;
		int calm;
		bit taken;
		taken_count = 0;
		calm = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			// long hold so the block fills up and pushes back
			if (taken_count == 80) begin
				pop = 1'b0;
				repeat (400) @(negedge clk);
			end
			if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 15);
				if ($urandom_range(0, 40) == 0)
					calm = 25;
			end
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do begin
				@(posedge clk);
				taken = !empty;
				@(negedge clk);
			end while (!taken);
			taken_count++;
		end
	end

	initial begin : stimulus
		logic [9:0] sx;
		logic [9:0] sy;
		logic [9:0] bs;
		logic [9:0] es;
		int lo;
		int hi;
		level_full = int'(bmma_pkg::FULL_RESET);
		level_empty = int'(bmma_pkg::EMPTY_RESET);
		level_low = int'(bmma_pkg::LOW_RESET);
		level_band = int'(bmma_pkg::DEADBAND_RESET);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes and the edges of the stick zone at reset levels
		send_samples(10'd0, 10'd0, 10'd0, 10'd0);
		send_samples(10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_samples(10'd512, 10'd512, 10'd1023, 10'd1023);
		send_samples(10'd481, 10'd543, 10'd1023, 10'd1000);
		send_samples(10'd480, 10'd512, 10'd1023, 10'd1023);
		send_samples(10'd512, 10'd544, 10'd700, 10'd700);
		send_samples(10'd0, 10'd1023, 10'd650, 10'd650);
		send_samples(10'd1023, 10'd0, 10'd650, 10'd900);
		drain();

		// lower full level keeps old window contents, zero deadband
		program_level(bmma_pkg::REG_FULL_LEVEL, 10'd800);
		program_level(bmma_pkg::REG_STICK_DEADBAND, 10'd0);
		cfg_valid = 1'b0;
		for (int i = 0; i < 8; i++)
			send_samples(10'd512, 10'd512, (i < 5) ? 10'd500 : 10'd790, 10'd500);
		drain();

		// full level not above empty level
		program_level(bmma_pkg::REG_EMPTY_LEVEL, 10'd900);
		program_level(bmma_pkg::REG_LOW_LEVEL, 10'd1023);
		cfg_valid = 1'b0;
		for (int i = 0; i < 6; i++)
			send_samples(10'd512, 10'd511, 10'd950, 10'd950);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0: apply_levels(1023, 0, 0, 512);
				1: apply_levels(0, 1023, 1023, 0);
				2: apply_levels(int'(bmma_pkg::FULL_RESET), int'(bmma_pkg::EMPTY_RESET),
					int'(bmma_pkg::LOW_RESET), int'(bmma_pkg::DEADBAND_RESET));
				3: apply_levels(1023, 1022, 1023, 1);
				4: apply_levels(700, 700, 700, 64);
				default: begin
					lo = $urandom_range(0, 1023);
					hi = $urandom_range(0, 1023);
					if ($urandom_range(0, 3) != 0 && lo > hi)
						apply_levels(lo, hi, $urandom_range(0, 1023), $urandom_range(0, 512));
					else
						apply_levels(hi, lo, $urandom_range(0, 1023), $urandom_range(0, 512));
				end
			endcase
			battery_target = $urandom_range(0, 1023);
			repeat (PHASE_ITEMS) begin
				draw_samples(sx, sy, bs, es);
				send_samples(sx, sy, bs, es);
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (board.mismatch_count == 0 && board.awaited_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
